@@ rtl/acsf_pkg.sv @@
// ----------------------------------------------------------------------------
// acsf_pkg: shared definitions for the anchored cosine similarity filter
// Widths, codes, saturation limits and the control structs passed between the
// element datapath, the cosine unit and the top level.
// ----------------------------------------------------------------------------
package acsf_pkg;

    localparam int VECTOR_DIM = 1024;
    localparam int IDX_W      = $clog2(VECTOR_DIM + 1);
    localparam int ADDR_W     = $clog2(VECTOR_DIM);

    localparam int ELEM_W = 16;
    localparam int TAG_W  = 20;
    localparam int SIM_W  = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 42;

    localparam int Q_W     = 15;
    localparam int BIT_W   = $clog2(Q_W);
    localparam int Q_SHIFT = 2 * (Q_W - 1);
    localparam int COS_W   = 2 * ACC_W + Q_SHIFT + 1;
    localparam int ONE_Q14 = 16384;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic REG_SIM_THRESHOLD = 1'b0;

    localparam logic FUNC_ANCHOR    = 1'b0;
    localparam logic FUNC_CANDIDATE = 1'b1;

    localparam logic [ACC_W-1:0] NORM_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] DOT_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] DOT_MIN  = {1'b1, {(ACC_W - 1){1'b0}}};

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_ANORM = 2'd1;
    localparam logic [1:0] ACC_CNORM = 2'd2;
    localparam logic [1:0] ACC_DOT   = 2'd3;

    typedef struct packed {
        logic       mul_en;
        logic       mul_anchor;
        logic [1:0] acc_sel;
        logic       first;
    } acsf_mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } acsf_cos_stat_t;

endpackage

@@ rtl/anchored_cosine_similarity_filter.sv @@
// ----------------------------------------------------------------------------
// anchored_cosine_similarity_filter: anchor/candidate cosine threshold filter
// Input channel (in_valid/in_ready) carries one vector element per transaction:
// func 0 for anchor elements, 1 for candidate elements, last_element ends a
// vector. Output channel (out_valid/out_ready) carries anchor_row,
// candidate_row and a Q1.14 similarity for each candidate that passes.
// The APB port holds similarity_threshold at byte address 0; pready is tied
// high and writes land on the access cycle.
// One transaction at a time: an anchor element passes the square and norm
// steps, a candidate element the square, norm and dot steps, all on the
// shared 16x16 multiplier and accumulators. A candidate's last element adds
// the cosine unit when both norms are nonzero: two shift-add products and a
// bit-by-bit root search. A finished result sits in the output register; input
// transactions keep flowing while it waits, and a new result waits in the
// block until that register is taken.
// Reset clears accumulators, lengths, the anchor tag and the threshold; the
// anchor store needs no clearing pass.
// ----------------------------------------------------------------------------
module anchored_cosine_similarity_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [acsf_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [acsf_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [acsf_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic signed [acsf_pkg::ELEM_W-1:0]     element_value,
    input  logic [acsf_pkg::TAG_W-1:0]             row_tag,
    input  logic                                   last_element,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [acsf_pkg::TAG_W-1:0]             anchor_row,
    output logic [acsf_pkg::TAG_W-1:0]             candidate_row,
    output logic signed [acsf_pkg::SIM_W-1:0]      similarity
);

    localparam int IW = acsf_pkg::IDX_W;
    localparam logic [IW-1:0] DIM_IDX = IW'(acsf_pkg::VECTOR_DIM);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_COS  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [IW-1:0]                 index_reg, index_next;
    logic [IW-1:0]                 len_reg, len_next;
    logic [acsf_pkg::TAG_W-1:0]    atag_reg, atag_next;
    logic [acsf_pkg::SIM_W-1:0]    thr_reg, thr_next;
    logic                          out_valid_reg, out_valid_next;

    logic [IW-1:0]                 p_reg;
    logic                          func_reg;
    logic [acsf_pkg::ELEM_W-1:0]   value_reg;
    logic [acsf_pkg::TAG_W-1:0]    tag_reg;
    logic                          last_reg;
    logic [acsf_pkg::TAG_W-1:0]    out_arow_reg;
    logic [acsf_pkg::TAG_W-1:0]    out_crow_reg;
    logic [acsf_pkg::SIM_W-1:0]    out_sim_reg;

    logic                          accept;
    logic                          in_range;
    logic                          load_out;
    logic                          cfg_wr;
    logic                          ram_we;
    logic [acsf_pkg::ELEM_W-1:0]   ram_rdata;
    logic signed [acsf_pkg::ELEM_W-1:0] anchor_op;

    acsf_pkg::acsf_mac_ctl_t       mac_ctl;
    logic [acsf_pkg::ACC_W-1:0]    anorm;
    logic [acsf_pkg::ACC_W-1:0]    cnorm;
    logic [acsf_pkg::ACC_W-1:0]    dot;

    logic                          cos_start;
    acsf_pkg::acsf_cos_stat_t      cos_stat;
    logic [acsf_pkg::SIM_W-1:0]    cos_sim;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_ready && in_valid;
    assign in_range = (index_reg < DIM_IDX);
    assign ram_we   = accept && in_range && (func == acsf_pkg::FUNC_ANCHOR);
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign anchor_op = (p_reg < len_reg) ? $signed(ram_rdata) : '0;

    acsf_anchor_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (accept),
        .addr  (index_reg[acsf_pkg::ADDR_W-1:0]),
        .wdata (element_value),
        .rdata (ram_rdata)
    );

    acsf_mac u_mac (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (mac_ctl),
        .elem              ($signed(value_reg)),
        .anchor_elem       (anchor_op),
        .anchor_norm_sq    (anorm),
        .candidate_norm_sq (cnorm),
        .dot               (dot)
    );

    acsf_cosine u_cos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cos_start),
        .dot   (dot),
        .na    (anorm),
        .nc    (cnorm),
        .stat  (cos_stat),
        .sim   (cos_sim)
    );

    always_comb
    begin
        state_next = state_reg;
        index_next = index_reg;
        len_next   = len_reg;
        atag_next  = atag_reg;
        thr_next   = thr_reg;
        load_out   = 1'b0;
        cos_start  = 1'b0;
        mac_ctl    = '0;

        if (cfg_wr && (paddr[acsf_pkg::REG_IDX_LSB] == acsf_pkg::REG_SIM_THRESHOLD))
        begin
            thr_next = pwdata[acsf_pkg::SIM_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (last_element)
                    begin
                        index_next = '0;
                    end
                    else if (in_range)
                    begin
                        index_next = index_reg + IW'(1);
                    end
                    if (in_range && (func == acsf_pkg::FUNC_ANCHOR))
                    begin
                        len_next  = index_reg + IW'(1);
                        atag_next = row_tag;
                    end
                    if (in_range)
                    begin
                        state_next = S_SQ;
                    end
                    else if ((func == acsf_pkg::FUNC_CANDIDATE) && last_element)
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_SQ:
            begin
                mac_ctl.mul_en = 1'b1;
                state_next     = S_NORM;
            end
            S_NORM:
            begin
                mac_ctl.first = (p_reg == '0);
                if (func_reg == acsf_pkg::FUNC_CANDIDATE)
                begin
                    mac_ctl.acc_sel    = acsf_pkg::ACC_CNORM;
                    mac_ctl.mul_en     = 1'b1;
                    mac_ctl.mul_anchor = 1'b1;
                    state_next         = S_DOT;
                end
                else
                begin
                    mac_ctl.acc_sel = acsf_pkg::ACC_ANORM;
                    state_next      = S_IDLE;
                end
            end
            S_DOT:
            begin
                mac_ctl.first   = (p_reg == '0);
                mac_ctl.acc_sel = acsf_pkg::ACC_DOT;
                state_next      = last_reg ? S_CHK : S_IDLE;
            end
            S_CHK:
            begin
                if ((anorm != '0) && (cnorm != '0))
                begin
                    cos_start  = 1'b1;
                    state_next = S_COS;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_COS:
            begin
                if (cos_stat.done)
                begin
                    state_next = ($signed(cos_sim) > $signed(thr_reg)) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            index_reg     <= '0;
            len_reg       <= '0;
            atag_reg      <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            len_reg       <= len_next;
            atag_reg      <= atag_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg     <= index_reg;
            func_reg  <= func;
            value_reg <= element_value;
            tag_reg   <= row_tag;
            last_reg  <= last_element;
        end
        if (load_out)
        begin
            out_arow_reg <= atag_reg;
            out_crow_reg <= tag_reg;
            out_sim_reg  <= cos_sim;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[acsf_pkg::REG_IDX_LSB] == acsf_pkg::REG_SIM_THRESHOLD)
                    ? {{(acsf_pkg::APB_DATA_W - acsf_pkg::SIM_W){thr_reg[acsf_pkg::SIM_W-1]}},
                       thr_reg}
                    : '0;

    assign out_valid     = out_valid_reg;
    assign anchor_row    = out_arow_reg;
    assign candidate_row = out_crow_reg;
    assign similarity    = $signed(out_sim_reg);

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_element) |=> (index_reg == '0))
        else $error("element index not rewound after last element");

    a_start_norms: assert property (@(posedge clk) disable iff (!rst_n)
        cos_start |-> ((anorm != '0) && (cnorm != '0)))
        else $error("cosine started with a zero norm");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        cos_stat.done |-> (($signed(cos_sim) <= acsf_pkg::ONE_Q14)
                           && ($signed(cos_sim) >= -acsf_pkg::ONE_Q14)))
        else $error("similarity outside plus or minus one");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cos_stat.busy |-> !in_ready)
        else $error("input ready while cosine unit busy");

endmodule

@@ rtl/acsf_anchor_ram.sv @@
// ----------------------------------------------------------------------------
// acsf_anchor_ram: anchor vector store
// Single-port memory holding the anchor components, registered read data.
// ----------------------------------------------------------------------------
module acsf_anchor_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic                        re,
    input  logic [acsf_pkg::ADDR_W-1:0] addr,
    input  logic [acsf_pkg::ELEM_W-1:0] wdata,
    output logic [acsf_pkg::ELEM_W-1:0] rdata
);

    logic [acsf_pkg::ELEM_W-1:0] mem [acsf_pkg::VECTOR_DIM];
    logic [acsf_pkg::ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/acsf_mac.sv @@
// ----------------------------------------------------------------------------
// acsf_mac: element multiply-accumulate datapath
// One 16x16 multiplier with a registered product feeding saturating
// accumulators for the anchor norm, candidate norm and dot product.
// ----------------------------------------------------------------------------
module acsf_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  acsf_pkg::acsf_mac_ctl_t            ctl,
    input  logic signed [acsf_pkg::ELEM_W-1:0] elem,
    input  logic signed [acsf_pkg::ELEM_W-1:0] anchor_elem,
    output logic [acsf_pkg::ACC_W-1:0]         anchor_norm_sq,
    output logic [acsf_pkg::ACC_W-1:0]         candidate_norm_sq,
    output logic [acsf_pkg::ACC_W-1:0]         dot
);

    localparam int AW = acsf_pkg::ACC_W;
    localparam int PW = acsf_pkg::PROD_W;

    logic signed [acsf_pkg::ELEM_W-1:0] mul_b;
    logic signed [PW-1:0]               prod_next;
    logic signed [PW-1:0]               prod_reg;

    logic [AW-1:0] anorm_reg;
    logic [AW-1:0] cnorm_reg;
    logic [AW-1:0] dot_reg;

    logic [AW-1:0] norm_base;
    logic [AW:0]   norm_sum;
    logic [AW-1:0] norm_sat;
    logic [AW-1:0] dot_base;
    logic [AW:0]   dot_sum;
    logic [AW-1:0] dot_sat;

    assign mul_b     = ctl.mul_anchor ? anchor_elem : elem;
    assign prod_next = elem * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        norm_base = '0;
        if (!ctl.first)
        begin
            norm_base = (ctl.acc_sel == acsf_pkg::ACC_ANORM) ? anorm_reg : cnorm_reg;
        end
        norm_sum = {1'b0, norm_base} + {{(AW + 1 - PW){1'b0}}, prod_reg};
        norm_sat = norm_sum[AW] ? acsf_pkg::NORM_MAX : norm_sum[AW-1:0];

        dot_base = ctl.first ? '0 : dot_reg;
        dot_sum  = {dot_base[AW-1], dot_base} + {{(AW + 1 - PW){prod_reg[PW-1]}}, prod_reg};
        if (dot_sum[AW] != dot_sum[AW-1])
        begin
            dot_sat = dot_sum[AW] ? acsf_pkg::DOT_MIN : acsf_pkg::DOT_MAX;
        end
        else
        begin
            dot_sat = dot_sum[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anorm_reg <= '0;
            cnorm_reg <= '0;
            dot_reg   <= '0;
        end
        else
        begin
            unique case (ctl.acc_sel)
                acsf_pkg::ACC_ANORM: anorm_reg <= norm_sat;
                acsf_pkg::ACC_CNORM: cnorm_reg <= norm_sat;
                acsf_pkg::ACC_DOT:   dot_reg   <= dot_sat;
                default:             ;
            endcase
        end
    end

    assign anchor_norm_sq    = anorm_reg;
    assign candidate_norm_sq = cnorm_reg;
    assign dot               = dot_reg;

endmodule

@@ rtl/acsf_cosine.sv @@
// ----------------------------------------------------------------------------
// acsf_cosine: iterative cosine similarity unit
// One shared wide adder, sequenced: shift-add products A*C and d*d, then a
// bit-by-bit search for the largest q with q*q*A*C <= d*d*2^28, q <= 1.0.
// ----------------------------------------------------------------------------
module acsf_cosine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [acsf_pkg::ACC_W-1:0]   dot,
    input  logic [acsf_pkg::ACC_W-1:0]   na,
    input  logic [acsf_pkg::ACC_W-1:0]   nc,
    output acsf_pkg::acsf_cos_stat_t     stat,
    output logic [acsf_pkg::SIM_W-1:0]   sim
);

    localparam int CW = acsf_pkg::COS_W;
    localparam int AW = acsf_pkg::ACC_W;
    localparam int QW = acsf_pkg::Q_W;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_MUL_P = 3'd1;
    localparam logic [2:0] C_MUL_R = 3'd2;
    localparam logic [2:0] C_SUM_X = 3'd3;
    localparam logic [2:0] C_SUM_P = 3'd4;
    localparam logic [2:0] C_CMP   = 3'd5;
    localparam logic [2:0] C_UPD   = 3'd6;
    localparam logic [2:0] C_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] q2p_reg, q2p_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] p2s_reg, p2s_next;
    logic [CW-1:0] r_reg, r_next;
    logic [AW-1:0] ml_reg, ml_next;
    logic [QW-1:0] q_reg, q_next;
    logic [acsf_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic ge_reg, ge_next;
    logic neg_reg, neg_next;
    logic [acsf_pkg::SIM_W-1:0] sim_reg, sim_next;

    logic [CW-1:0] add_a;
    logic [CW-1:0] add_b;
    logic          add_sub;
    logic [CW:0]   add_full;
    logic [CW-1:0] add_sum;
    logic          add_carry;

    logic [AW-1:0] dot_abs;
    logic [acsf_pkg::SIM_W-1:0] q_ext;
    logic [acsf_pkg::SIM_W-1:0] sim_calc;

    assign dot_abs  = dot[AW-1] ? (~dot + AW'(1)) : dot;
    assign q_ext    = acsf_pkg::SIM_W'(q_reg);
    assign sim_calc = neg_reg ? (~q_ext + acsf_pkg::SIM_W'(1)) : q_ext;

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            C_MUL_P, C_MUL_R:
            begin
                add_a = t_reg;
                add_b = x_reg;
            end
            C_SUM_X:
            begin
                add_a = q2p_reg;
                add_b = x_reg;
            end
            C_SUM_P:
            begin
                add_a = t_reg;
                add_b = p2s_reg;
            end
            C_CMP:
            begin
                add_a   = r_reg;
                add_b   = t_reg;
                add_sub = 1'b1;
            end
            C_UPD:
            begin
                add_a = {1'b0, x_reg[CW-1:1]};
                add_b = ge_reg ? p2s_reg : '0;
            end
            default: ;
        endcase
        add_full  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                    + (CW + 1)'(add_sub);
        add_sum   = add_full[CW-1:0];
        add_carry = add_full[CW];
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        q2p_next   = q2p_reg;
        x_next     = x_reg;
        p2s_next   = p2s_reg;
        r_next     = r_reg;
        ml_next    = ml_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        ge_next    = ge_reg;
        neg_next   = neg_reg;
        sim_next   = sim_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    t_next     = '0;
                    x_next     = CW'(na);
                    ml_next    = nc;
                    neg_next   = dot[AW-1];
                    state_next = C_MUL_P;
                end
            end
            C_MUL_P, C_MUL_R:
            begin
                if (ml_reg == '0)
                begin
                    if (state_reg == C_MUL_P)
                    begin
                        p2s_next   = t_reg << acsf_pkg::Q_SHIFT;
                        t_next     = '0;
                        x_next     = CW'(dot_abs);
                        ml_next    = dot_abs;
                        state_next = C_MUL_R;
                    end
                    else
                    begin
                        r_next     = t_reg << acsf_pkg::Q_SHIFT;
                        q2p_next   = '0;
                        x_next     = '0;
                        q_next     = '0;
                        bit_next   = acsf_pkg::BIT_W'(QW - 1);
                        state_next = C_SUM_X;
                    end
                end
                else
                begin
                    if (ml_reg[0])
                    begin
                        t_next = add_sum;
                    end
                    x_next  = x_reg << 1;
                    ml_next = ml_reg >> 1;
                end
            end
            C_SUM_X:
            begin
                if (q_reg[QW-1])
                begin
                    sim_next   = sim_calc;
                    state_next = C_DONE;
                end
                else
                begin
                    t_next     = add_sum;
                    state_next = C_SUM_P;
                end
            end
            C_SUM_P:
            begin
                t_next     = add_sum;
                state_next = C_CMP;
            end
            C_CMP:
            begin
                ge_next = add_carry;
                if (add_carry)
                begin
                    q2p_next         = t_reg;
                    q_next[bit_reg]  = 1'b1;
                end
                state_next = C_UPD;
            end
            C_UPD:
            begin
                x_next   = add_sum;
                p2s_next = p2s_reg >> 2;
                if (bit_reg == '0)
                begin
                    sim_next   = sim_calc;
                    state_next = C_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - acsf_pkg::BIT_W'(1);
                    state_next = C_SUM_X;
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        q2p_reg <= q2p_next;
        x_reg   <= x_next;
        p2s_reg <= p2s_next;
        r_reg   <= r_next;
        ml_reg  <= ml_next;
        q_reg   <= q_next;
        bit_reg <= bit_next;
        ge_reg  <= ge_next;
        neg_reg <= neg_next;
        sim_reg <= sim_next;
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_DONE);
    assign sim       = sim_reg;

endmodule

@@ test/acsf_similarity_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsf_similarity_checker: scoreboard for the anchored cosine similarity filter
// Watches the APB port and both streaming channels. Keeps its own copy of the
// anchor vector, the norms, the dot product and the threshold. Predicts the
// Q1.14 similarity result of each candidate vector and checks every result
// that leaves the block, in order, field by field.
// ----------------------------------------------------------------------------
module acsf_similarity_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [acsf_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [acsf_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic                                   pready,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   func,
    input  logic signed [acsf_pkg::ELEM_W-1:0]     element_value,
    input  logic [acsf_pkg::TAG_W-1:0]             row_tag,
    input  logic                                   last_element,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [acsf_pkg::TAG_W-1:0]             anchor_row,
    input  logic [acsf_pkg::TAG_W-1:0]             candidate_row,
    input  logic signed [acsf_pkg::SIM_W-1:0]      similarity,
    output int                                     outstanding,
    output int                                     mismatches,
    output int                                     results_checked
);

    import acsf_pkg::*;

    localparam longint DOT_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint DOT_LO   = -DOT_HI - 1;
    localparam longint NORM_CAP = (longint'(1) <<< ACC_W) - 1;

    typedef struct packed {
        logic [TAG_W-1:0]        anchor_row;
        logic [TAG_W-1:0]        candidate_row;
        logic signed [SIM_W-1:0] similarity;
    } match_t;

    match_t                   expected_matches [$];
    logic signed [ELEM_W-1:0] anchor_vec [VECTOR_DIM];
    logic [IDX_W-1:0]         anchor_count;
    logic [TAG_W-1:0]         anchor_id;
    logic [ACC_W-1:0]         anchor_energy;
    logic [IDX_W-1:0]         elem_pos;
    logic signed [ACC_W-1:0]  dot_sum;
    logic [ACC_W-1:0]         cand_energy;
    int                       sim_floor;

    function automatic int cos_ratio_q14(input longint dot, input longint na, input longint nc);
        logic [127:0] bound;
        logic [127:0] trial;
        logic [63:0]  mag;
        int           q;
        int           t;
        int           b;
        mag = (dot < 0) ? -dot : dot;
        bound = (128'(mag) * 128'(mag)) << Q_SHIFT;
        q = 0;
        for (b = Q_W - 1; b >= 0; b--)
        begin
            t = q | (1 << b);
            if (t <= ONE_Q14)
            begin
                trial = 128'(t) * 128'(t) * 128'(na) * 128'(nc);
                if (trial <= bound)
                    q = t;
            end
        end
        return (dot < 0) ? -q : q;
    endfunction

    task automatic track_element(input logic kind, input logic signed [ELEM_W-1:0] v,
                                 input logic [TAG_W-1:0] tag, input logic last);
        longint sq;
        longint acc;
        int     cos;
        match_t m;
        if (elem_pos < VECTOR_DIM)
        begin
            sq = longint'(v) * longint'(v);
            if (kind == FUNC_ANCHOR)
            begin
                if (elem_pos == 0)
                begin
                    anchor_energy = '0;
                    anchor_count  = '0;
                end
                anchor_vec[elem_pos[ADDR_W-1:0]] = v;
                anchor_count = elem_pos + IDX_W'(1);
                anchor_id = tag;
                acc = longint'(anchor_energy) + sq;
                if (acc > NORM_CAP)
                    acc = NORM_CAP;
                anchor_energy = acc[ACC_W-1:0];
            end
            else
            begin
                if (elem_pos == 0)
                begin
                    dot_sum     = '0;
                    cand_energy = '0;
                end
                if (elem_pos < anchor_count)
                begin
                    acc = longint'(dot_sum)
                          + longint'(v) * longint'(anchor_vec[elem_pos[ADDR_W-1:0]]);
                    if (acc > DOT_HI)
                        acc = DOT_HI;
                    if (acc < DOT_LO)
                        acc = DOT_LO;
                    dot_sum = acc[ACC_W-1:0];
                end
                acc = longint'(cand_energy) + sq;
                if (acc > NORM_CAP)
                    acc = NORM_CAP;
                cand_energy = acc[ACC_W-1:0];
            end
            elem_pos = elem_pos + IDX_W'(1);
        end
        if (kind == FUNC_CANDIDATE && last && anchor_energy != 0 && cand_energy != 0)
        begin
            cos = cos_ratio_q14(longint'(dot_sum), longint'(anchor_energy),
                                longint'(cand_energy));
            if (cos > sim_floor)
            begin
                m.anchor_row    = anchor_id;
                m.candidate_row = tag;
                m.similarity    = cos[SIM_W-1:0];
                expected_matches.insert(expected_matches.size(), m);
            end
        end
        if (last)
            elem_pos = '0;
    endtask

    task automatic check_result();
        match_t want;
        if (expected_matches.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: anchor_row %h candidate_row %h similarity %0d",
                         anchor_row, candidate_row, similarity);
        end
        else
        begin
            want = expected_matches.pop_front();
            results_checked++;
            if (want.anchor_row !== anchor_row || want.candidate_row !== candidate_row ||
                want.similarity !== similarity)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h %h %0d, got %h %h %0d",
                             want.anchor_row, want.candidate_row, want.similarity,
                             anchor_row, candidate_row, similarity);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_matches.delete();
            anchor_count    = '0;
            anchor_id       = '0;
            anchor_energy   = '0;
            elem_pos        = '0;
            dot_sum         = '0;
            cand_energy     = '0;
            sim_floor       = 0;
            outstanding     = 0;
            mismatches      = 0;
            results_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                track_element(func, element_value, row_tag, last_element);
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_SIM_THRESHOLD)
                sim_floor = int'($signed(pwdata[SIM_W-1:0]));
            outstanding = expected_matches.size();
        end
    end

endmodule

@@ test/tb_anchored_cosine_similarity_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anchored_cosine_similarity_filter: stimulus and verdict for the filter
// Loads anchors and streams candidate vectors through the valid/ready input,
// with a directed opening, threshold sweeps over the APB port, random vectors
// correlated with the anchor, broken sequences and one overlong candidate.
// Both channels stall at random; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_anchored_cosine_similarity_filter;

    import acsf_pkg::*;

    localparam int VEC_ANCHOR    = 0;
    localparam int VEC_CANDIDATE = 1;
    localparam int VEC_NOISE     = 2;
    localparam int PHASES        = 6;
    localparam int LONG_PHASE    = 2;
    localparam int CALM_PHASE    = 3;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LONG_LEN      = VECTOR_DIM + 6;
    localparam logic [APB_ADDR_W-1:0] THRESH_ADDR =
        {{(APB_ADDR_W - 1){1'b0}}, REG_SIM_THRESHOLD} << REG_IDX_LSB;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic                     func;
    logic signed [ELEM_W-1:0] element_value;
    logic [TAG_W-1:0]         row_tag;
    logic                     last_element;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [TAG_W-1:0]         anchor_row;
    logic [TAG_W-1:0]         candidate_row;
    logic signed [SIM_W-1:0]  similarity;

    logic                     calm = 1'b0;
    int                       outstanding;
    int                       mismatches;
    int                       results_checked;
    int                       items_sent = 0;
    logic signed [ELEM_W-1:0] anchor_copy [$];

    anchored_cosine_similarity_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .element_value (element_value),
        .row_tag       (row_tag),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .anchor_row    (anchor_row),
        .candidate_row (candidate_row),
        .similarity    (similarity)
    );

    acsf_similarity_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .element_value   (element_value),
        .row_tag         (row_tag),
        .last_element    (last_element),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .anchor_row      (anchor_row),
        .candidate_row   (candidate_row),
        .similarity      (similarity),
        .outstanding     (outstanding),
        .mismatches      (mismatches),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("anchored_cosine_similarity_filter test failed");
        $finish;
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 11);

    function automatic logic signed [ELEM_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return ELEM_W'($urandom_range(0, 255)) - 16'sd128;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic push_element(input logic kind, input logic signed [ELEM_W-1:0] v,
                                input logic [TAG_W-1:0] tag, input logic last);
        int gap;
        gap = (!calm && $urandom_range(99) < 11) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= kind;
        element_value <= v;
        row_tag       <= tag;
        last_element  <= last;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_vector(input int kind, input int len);
        logic [TAG_W-1:0]         tag;
        logic signed [ELEM_W-1:0] v;
        int                       mode;
        int                       a;
        tag  = TAG_W'($urandom);
        mode = $urandom_range(3);
        if (kind == VEC_ANCHOR)
            anchor_copy.delete();
        for (int i = 0; i < len; i++)
        begin
            if (kind == VEC_ANCHOR)
            begin
                v = rand_value();
                anchor_copy.insert(anchor_copy.size(), v);
                push_element(FUNC_ANCHOR, v, tag, i == len - 1);
            end
            else if (kind == VEC_CANDIDATE)
            begin
                if (i < anchor_copy.size() && mode != 0)
                begin
                    case (mode)
                        1:       a = int'(anchor_copy[i]) + int'($urandom_range(0, 64)) - 32;
                        2:       a = -int'(anchor_copy[i]) + int'($urandom_range(0, 64)) - 32;
                        default: a = int'(anchor_copy[i]) >>> 1;
                    endcase
                    if (a > 32767)
                        a = 32767;
                    if (a < -32768)
                        a = -32768;
                    v = a[ELEM_W-1:0];
                end
                else
                    v = rand_value();
                push_element(FUNC_CANDIDATE, v, tag, i == len - 1);
            end
            else
                push_element(1'($urandom), rand_value(), TAG_W'($urandom),
                             $urandom_range(3) == 0);
        end
    endtask

    initial
    begin : stimulus
        int thresholds [PHASES];
        int budget;
        int start;
        int r;
        int len;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_ANCHOR;
        element_value <= '0;
        row_tag       <= '0;
        last_element  <= 1'b0;
        thresholds = '{0, ONE_Q14, -ONE_Q14, 8192, 0, -8000};
        thresholds[4] = int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_element(FUNC_CANDIDATE, 16'sd100, 20'h00005, 1'b1);
        wait_drained();
        apb_write(THRESH_ADDR, -ONE_Q14);

        push_element(FUNC_ANCHOR, 16'sh7FFF, 20'hFFFFF, 1'b0);
        push_element(FUNC_ANCHOR, 16'sh8000, 20'hFFFFF, 1'b0);
        push_element(FUNC_ANCHOR, 16'sh0000, 20'hFFFFF, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sh7FFF, 20'h00000, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sh8000, 20'h00000, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sh0000, 20'h00000, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sh8000, 20'h00011, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sh7FFF, 20'h00011, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sh0000, 20'h00011, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sh0000, 20'h00022, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sh0000, 20'h00022, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sd1, 20'h00033, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd2, 20'h00033, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd3, 20'h00033, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd4, 20'h00033, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd5, 20'h00033, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sd0, 20'h00044, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd0, 20'h00044, 1'b0);
        push_element(FUNC_CANDIDATE, 16'sd1234, 20'h00044, 1'b1);
        push_element(FUNC_ANCHOR, 16'sd4000, 20'h00007, 1'b0);
        push_element(FUNC_CANDIDATE, -16'sd500, 20'h00008, 1'b1);
        push_element(FUNC_ANCHOR, 16'sd0, 20'h00009, 1'b1);
        push_element(FUNC_CANDIDATE, 16'sd77, 20'h0000A, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            apb_write(THRESH_ADDR, thresholds[ph]);
            calm = (ph == CALM_PHASE);
            if (ph == LONG_PHASE)
            begin
                send_vector(VEC_CANDIDATE, LONG_LEN);
            end
            budget = (thresholds[ph] >= ONE_Q14) ? 80 : 150;
            start = items_sent;
            while (items_sent - start < budget)
            begin
                r = $urandom_range(99);
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_vector(r < 15 ? VEC_ANCHOR : (r < 88 ? VEC_CANDIDATE : VEC_NOISE), len);
            end
        end
        calm = 1'b0;
        wait_drained();

        $display("covered %0d element transactions over %0d threshold settings, with anchor reloads,",
                 items_sent, PHASES + 2);
        $display("broken sequences and vectors past %0d elements; %0d results checked in order",
                 VECTOR_DIM, results_checked);
        if (mismatches == 0)
            $display("anchored_cosine_similarity_filter test passed");
        else
            $display("anchored_cosine_similarity_filter test failed");
        $finish;
    end

endmodule

@@ anchored_cosine_similarity_filter.f @@
rtl/acsf_pkg.sv
rtl/acsf_anchor_ram.sv
rtl/acsf_mac.sv
rtl/acsf_cosine.sv
rtl/anchored_cosine_similarity_filter.sv
test/acsf_similarity_checker.sv
test/tb_anchored_cosine_similarity_filter.sv
